/* rtl/amb_pkg.sv */
// amb_pkg: shared types and constants of the alpha mask pixel blend unit
// no dependencies; used by every module of the block

package amb_pkg;

  // default sizes handed down from the top level
  localparam int COORD_WIDTH_DEFAULT = 12;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int CLIP_W      = 13;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_COLOR   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GLOBAL_ALPHA = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEFT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_TOP     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_RIGHT   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_BOTTOM  = 3'd5;

  // register reset values
  localparam logic [23:0]       FILL_COLOR_RESET   = 24'h000000;
  localparam logic [7:0]        GLOBAL_ALPHA_RESET = 8'd255;
  localparam logic [CLIP_W-1:0] CLIP_LO_RESET      = 13'd0;
  localparam logic [CLIP_W-1:0] CLIP_HI_RESET      = 13'd4096;

  // full coverage after alpha scaling
  localparam logic [7:0] ALPHA_FULL = 8'd255;

  // clip window, from the register file to the front
  typedef struct packed {
    logic [CLIP_W-1:0] left;
    logic [CLIP_W-1:0] top;
    logic [CLIP_W-1:0] right;
    logic [CLIP_W-1:0] bottom;
  } clip_t;

  // blend settings, from the register file to the back
  typedef struct packed {
    logic [23:0] fill_color;
    logic [7:0]  global_alpha;
  } blend_cfg_t;

  // one classified pixel waiting in the queue
  typedef struct packed {
    logic        write;
    logic [7:0]  coverage;
    logic [23:0] dest;
  } item_t;

endpackage

/* rtl/amb_front.sv */
// amb_front: accepts pixels and classifies them against the clip window
// depends on amb_pkg (clip_t, item_t)

module amb_front #(
  parameter int COORD_WIDTH = amb_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] pos_x,
  input  logic [COORD_WIDTH-1:0] pos_y,
  input  logic [23:0]            dest_pixel,
  input  logic [7:0]             coverage,
  input  amb_pkg::clip_t         clip,
  input  logic                   q_full,
  output logic                   q_push,
  output amb_pkg::item_t         q_item
);

  localparam int CMP_W = (COORD_WIDTH > amb_pkg::CLIP_W) ? COORD_WIDTH : amb_pkg::CLIP_W;

  logic [CMP_W-1:0] x_ext;
  logic [CMP_W-1:0] y_ext;
  logic             in_win;

  // window test on zero-extended values
  always_comb begin
    x_ext  = CMP_W'(pos_x);
    y_ext  = CMP_W'(pos_y);
    in_win = (x_ext >= CMP_W'(clip.left)) && (x_ext < CMP_W'(clip.right)) &&
             (y_ext >= CMP_W'(clip.top))  && (y_ext < CMP_W'(clip.bottom));
  end

  // transfer into the queue whenever it has room
  assign in_stall        = q_full;
  assign q_push          = in_valid && !q_full;
  assign q_item.write    = in_win && (coverage != 8'd0);
  assign q_item.coverage = coverage;
  assign q_item.dest     = dest_pixel;

endmodule

/* rtl/amb_queue.sv */
// amb_queue: short fifo of classified pixels between front and back
// depends on amb_pkg (item_t)

module amb_queue #(
  parameter int QUEUE_DEPTH = amb_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_push,
  input  amb_pkg::item_t q_item_in,
  output logic           q_full,
  output logic           q_valid,
  output amb_pkg::item_t q_item_out,
  input  logic           q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  amb_pkg::item_t   mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_full     = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid    = (count != '0);
  assign q_item_out = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (q_push) begin
      mem[wr_ptr] <= q_item_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (q_push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !q_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
`endif

endmodule

/* rtl/amb_back.sv */
// amb_back: alpha scaling and per-channel blend pipeline with output register
// depends on amb_pkg (item_t, blend_cfg_t, ALPHA_FULL)

module amb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  amb_pkg::item_t      q_item,
  output logic                q_pop,
  input  amb_pkg::blend_cfg_t cfg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [23:0]         new_pixel,
  output logic                write_enable
);

  logic adv;

  // stage 1: coverage times global alpha
  logic        s1_valid;
  logic        s1_write;
  logic [23:0] s1_dest;
  logic [15:0] s1_prod;

  // stage 2: scaled coverage, weight and channel products
  logic              s2_valid;
  logic              s2_write;
  logic              s2_full;
  logic [23:0]       s2_dest;
  logic signed [18:0] s2_v [3];

  logic [16:0]        div_sum;
  logic [7:0]         alpha;
  logic [8:0]         weight;
  logic signed [18:0] v_next [3];
  logic signed [8:0]  diff   [3];
  logic [23:0]        mix;

  // whole pipeline moves when the output register is free or being taken
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_valid;

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_write <= q_item.write;
      s1_dest  <= q_item.dest;
      s1_prod  <= q_item.coverage * cfg.global_alpha;
    end
  end

  // truncating divide by 255, exact for products up to 65534
  always_comb begin
    div_sum = {1'b0, s1_prod} + 17'd1 + {9'b0, s1_prod[15:8]};
    alpha   = div_sum[15:8];
    weight  = {1'b0, alpha} + {8'b0, alpha[7]};
    for (int i = 0; i < 3; i++) begin
      diff[i]   = $signed({1'b0, cfg.fill_color[8*i +: 8]}) -
                  $signed({1'b0, s1_dest[8*i +: 8]});
      v_next[i] = 19'(diff[i] * $signed({1'b0, weight})) + 19'sd128;
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_write <= s1_write;
      s2_full  <= (alpha == amb_pkg::ALPHA_FULL);
      s2_dest  <= s1_dest;
      for (int i = 0; i < 3; i++) begin
        s2_v[i] <= v_next[i];
      end
    end
  end

  // floor shift by 8, only the low byte of the quotient matters
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix[8*i +: 8] = s2_dest[8*i +: 8] + s2_v[i][15:8];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      write_enable <= s2_write;
      if (!s2_write) begin
        new_pixel <= s2_dest;
      end else if (s2_full) begin
        new_pixel <= cfg.fill_color;
      end else begin
        new_pixel <= mix;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_stage1_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv) |=> s2_valid)
    else $error("stage 1 item lost");
  a_stage2_moves: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && adv) |=> out_valid)
    else $error("stage 2 item lost");
  a_pop_only_on_adv: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !q_pop)
    else $error("queue popped while pipeline held");
`endif

endmodule

/* rtl/alpha_mask_pixel_blend_unit.sv */
// Alpha mask pixel blend unit: while out_stall is low it takes one pixel per clock and
// returns one result per clock. A pixel passes the clip window compare in the front, waits
// in a QUEUE_DEPTH-entry fifo, then runs through a three-register back pipeline (alpha
// multiply, divide-by-255 and channel multiply, output register) before it is shown.
// in_stall rises only once the fifo has filled behind a stalled output.
// Configuration is held in a write-only register file here. Depends on amb_pkg,
// amb_front, amb_queue and amb_back.

module alpha_mask_pixel_blend_unit #(
  parameter int COORD_WIDTH = amb_pkg::COORD_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = amb_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [amb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [amb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [COORD_WIDTH-1:0]          pos_x,
  input  logic [COORD_WIDTH-1:0]          pos_y,
  input  logic [23:0]                     dest_pixel,
  input  logic [7:0]                      coverage,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [23:0]                     new_pixel,
  output logic                            write_enable
);

  amb_pkg::clip_t      clip;
  amb_pkg::blend_cfg_t blend_cfg;

  logic           q_full;
  logic           q_push;
  logic           q_valid;
  logic           q_pop;
  amb_pkg::item_t q_item_in;
  amb_pkg::item_t q_item_out;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_cfg.fill_color   <= amb_pkg::FILL_COLOR_RESET;
      blend_cfg.global_alpha <= amb_pkg::GLOBAL_ALPHA_RESET;
      clip.left              <= amb_pkg::CLIP_LO_RESET;
      clip.top               <= amb_pkg::CLIP_LO_RESET;
      clip.right             <= amb_pkg::CLIP_HI_RESET;
      clip.bottom            <= amb_pkg::CLIP_HI_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        amb_pkg::REG_FILL_COLOR:   blend_cfg.fill_color   <= cfg_data[23:0];
        amb_pkg::REG_GLOBAL_ALPHA: blend_cfg.global_alpha <= cfg_data[7:0];
        amb_pkg::REG_CLIP_LEFT:    clip.left   <= cfg_data[amb_pkg::CLIP_W-1:0];
        amb_pkg::REG_CLIP_TOP:     clip.top    <= cfg_data[amb_pkg::CLIP_W-1:0];
        amb_pkg::REG_CLIP_RIGHT:   clip.right  <= cfg_data[amb_pkg::CLIP_W-1:0];
        amb_pkg::REG_CLIP_BOTTOM:  clip.bottom <= cfg_data[amb_pkg::CLIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and classify
  amb_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .dest_pixel(dest_pixel),
    .coverage  (coverage),
    .clip      (clip),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item_in)
  );

  // queue between front and back
  amb_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .q_push    (q_push),
    .q_item_in (q_item_in),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_item_out(q_item_out),
    .q_pop     (q_pop)
  );

  // back: scale and blend
  amb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item_out),
    .q_pop       (q_pop),
    .cfg         (blend_cfg),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .new_pixel   (new_pixel),
    .write_enable(write_enable)
  );

endmodule

/* test/tb.sv */
// tb: self-checking testbench for alpha_mask_pixel_blend_unit, clip, coverage and blend paths
// depends on amb_pkg and the alpha_mask_pixel_blend_unit rtl; predicts every result in-line

module tb;

  localparam int CW = amb_pkg::COORD_WIDTH_DEFAULT;
  localparam int COORD_MAX = (1 << CW) - 1;
  localparam int PIPE_LATENCY = 4;
  localparam int PHASE_COUNT = 9;
  localparam int PHASE_PIXELS = 100;
  localparam logic [amb_pkg::CFG_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [amb_pkg::CFG_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;
  localparam logic [23:0] WHITE = 24'hFFFFFF;
  localparam logic [23:0] BLACK = 24'h000000;
  localparam logic [CW-1:0] CMAX = CW'(COORD_MAX);

  typedef struct packed {
    logic [23:0] pixel;
    logic        written;
  } blend_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [amb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [amb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CW-1:0] pos_x = '0;
  logic [CW-1:0] pos_y = '0;
  logic [23:0] dest_pixel = '0;
  logic [7:0] coverage = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [23:0] new_pixel;
  logic write_enable;

  // shadow copy of the register file
  logic [23:0] fill_reg = amb_pkg::FILL_COLOR_RESET;
  logic [7:0] alpha_reg = amb_pkg::GLOBAL_ALPHA_RESET;
  logic [amb_pkg::CLIP_W-1:0] clip_l = amb_pkg::CLIP_LO_RESET;
  logic [amb_pkg::CLIP_W-1:0] clip_tp = amb_pkg::CLIP_LO_RESET;
  logic [amb_pkg::CLIP_W-1:0] clip_r = amb_pkg::CLIP_HI_RESET;
  logic [amb_pkg::CLIP_W-1:0] clip_b = amb_pkg::CLIP_HI_RESET;

  blend_result_t pending_pixels[$];
  blend_result_t head_result;
  logic idle_on = 1'b1;
  int stall_left = 0;
  int errors = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int pixels_written = 0;
  int settings_used = 0;

  alpha_mask_pixel_blend_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .dest_pixel(dest_pixel),
    .coverage(coverage),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .new_pixel(new_pixel),
    .write_enable(write_enable)
  );

  always #1 clk = ~clk;

  // one channel: d + floor(((c - d) * w + 128) / 256), wrapped to 8 bits
  function automatic logic [7:0] blend_channel(input logic [7:0] d, input logic [7:0] c,
                                               input int w);
    int v;
    int sum;
    v = (int'(c) - int'(d)) * w + 128;
    sum = int'(d) + (v >>> 8);
    return sum[7:0];
  endfunction

  // expected result of one pixel under the current register settings
  function automatic blend_result_t predict_pixel(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y,
                                                  input logic [23:0] d, input logic [7:0] a);
    blend_result_t r;
    logic in_window;
    int s;
    int w;
    in_window = (x >= clip_l) && (x < clip_r) && (y >= clip_tp) && (y < clip_b);
    r.pixel = d;
    r.written = 1'b0;
    if (!in_window || a == 8'd0) return r;
    s = int'(a);
    if (alpha_reg != amb_pkg::ALPHA_FULL) s = s * int'(alpha_reg) / 255;
    r.written = 1'b1;
    if (s >= 255) begin
      r.pixel = fill_reg;
    end else begin
      w = s + (s >> 7);
      r.pixel = {blend_channel(d[23:16], fill_reg[23:16], w),
                 blend_channel(d[15:8], fill_reg[15:8], w),
                 blend_channel(d[7:0], fill_reg[7:0], w)};
    end
    return r;
  endfunction

  // random receiver stall bursts, started only while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check, sampled mid-cycle where every signal is settled
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: new_pixel %h write_enable %b", new_pixel, write_enable);
        errors++;
      end else begin
        head_result = pending_pixels.pop_front();
        results_checked++;
        if (new_pixel !== head_result.pixel) begin
          $error("new_pixel: expected %h, got %h", head_result.pixel, new_pixel);
          errors++;
        end
        if (write_enable !== head_result.written) begin
          $error("write_enable: expected %b, got %b", head_result.written, write_enable);
          errors++;
        end
      end
    end
  end

  // one pixel transfer; returns right after the edge that accepted it
  task automatic send_pixel(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic [23:0] d, input logic [7:0] a);
    blend_result_t r;
    in_valid <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    dest_pixel <= d;
    coverage <= a;
    do @(negedge clk); while (in_stall);
    r = predict_pixel(x, y, d, a);
    pending_pixels.push_back(r);
    pixels_sent++;
    if (r.written) pixels_written++;
    @(posedge clk);
  endtask

  task automatic sender_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every expected result has come back
  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_results();
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // register write; unknown indexes leave the shadow copy alone
  task automatic write_reg(input logic [amb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [amb_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      amb_pkg::REG_FILL_COLOR: fill_reg = data[23:0];
      amb_pkg::REG_GLOBAL_ALPHA: alpha_reg = data[7:0];
      amb_pkg::REG_CLIP_LEFT: clip_l = data[amb_pkg::CLIP_W-1:0];
      amb_pkg::REG_CLIP_TOP: clip_tp = data[amb_pkg::CLIP_W-1:0];
      amb_pkg::REG_CLIP_RIGHT: clip_r = data[amb_pkg::CLIP_W-1:0];
      amb_pkg::REG_CLIP_BOTTOM: clip_b = data[amb_pkg::CLIP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // unused upper data bits get random values
  task automatic write_clip(input int l, input int t, input int r, input int b);
    write_reg(amb_pkg::REG_CLIP_LEFT, {11'($urandom_range(0, 2047)), l[amb_pkg::CLIP_W-1:0]});
    write_reg(amb_pkg::REG_CLIP_TOP, {11'($urandom_range(0, 2047)), t[amb_pkg::CLIP_W-1:0]});
    write_reg(amb_pkg::REG_CLIP_RIGHT, {11'($urandom_range(0, 2047)), r[amb_pkg::CLIP_W-1:0]});
    write_reg(amb_pkg::REG_CLIP_BOTTOM, {11'($urandom_range(0, 2047)), b[amb_pkg::CLIP_W-1:0]});
    settings_used++;
  endtask

  task automatic write_alpha(input logic [7:0] alpha);
    write_reg(amb_pkg::REG_GLOBAL_ALPHA, {16'($urandom_range(0, 65535)), alpha});
  endtask

  // defaults after reset: black fill, opaque, full window
  task automatic test_reset_defaults();
    send_pixel(0, 0, WHITE, 8'd255);
    send_pixel(CMAX, CMAX, 24'h123456, 8'd0);
    send_pixel(CMAX, 0, WHITE, 8'd128);
    send_pixel(0, CMAX, BLACK, 8'd1);
    drain();
  endtask

  // weight edges, both blend directions, scaled coverage reaching zero
  task automatic test_blend_weights();
    write_reg(amb_pkg::REG_FILL_COLOR, WHITE);
    settings_used++;
    send_pixel(10, 10, BLACK, 8'd127);
    send_pixel(10, 10, BLACK, 8'd128);
    send_pixel(10, 10, 24'h00FF80, 8'd254);
    drain();
    write_alpha(8'd0);
    send_pixel(5, 5, 24'h0A0B0C, 8'd255);
    drain();
    write_alpha(8'd1);
    send_pixel(5, 5, BLACK, 8'd254);
    send_pixel(5, 5, BLACK, 8'd255);
    drain();
    write_alpha(8'd254);
    write_reg(amb_pkg::REG_FILL_COLOR, BLACK);
    send_pixel(5, 5, WHITE, 8'd255);
    send_pixel(5, 5, 24'hC08040, 8'd200);
    drain();
    write_alpha(amb_pkg::ALPHA_FULL);
  endtask

  // single-pixel window, inverted window, bounds past 4096
  task automatic test_clip_edges();
    write_clip(100, 200, 101, 201);
    send_pixel(99, 200, 24'h112233, 8'd200);
    send_pixel(100, 200, 24'h112233, 8'd200);
    send_pixel(101, 200, 24'h112233, 8'd200);
    send_pixel(100, 199, 24'h112233, 8'd200);
    send_pixel(100, 201, 24'h112233, 8'd200);
    drain();
    write_clip(200, 100, 100, 300);
    send_pixel(150, 150, 24'h445566, 8'd90);
    drain();
    write_clip(4096, 0, 8191, 8191);
    send_pixel(CMAX, 50, 24'h778899, 8'd255);
    drain();
    write_clip(0, 0, 8191, 8191);
    send_pixel(CMAX, CMAX, 24'h778899, 8'd60);
    send_pixel(0, 0, 24'hFEDCBA, 8'd255);
    drain();
  endtask

  // writes to unused indexes must change nothing
  task automatic test_unknown_index();
    write_reg(REG_UNUSED_6, WHITE);
    write_reg(REG_UNUSED_7, 24'h5A5A5A);
    send_pixel(20, 30, 24'h808080, 8'd255);
    send_pixel(20, 30, 24'h808080, 8'd77);
    drain();
  endtask

  // random register setting, extremes weighted in
  task automatic pick_setting();
    int l;
    int t;
    case ($urandom_range(0, 3))
      0: write_reg(amb_pkg::REG_FILL_COLOR, BLACK);
      1: write_reg(amb_pkg::REG_FILL_COLOR, WHITE);
      default: write_reg(amb_pkg::REG_FILL_COLOR, 24'($urandom_range(0, 24'hFFFFFF)));
    endcase
    case ($urandom_range(0, 5))
      0: write_alpha(8'd0);
      1: write_alpha(8'd1);
      2: write_alpha(8'd254);
      3, 4: write_alpha(amb_pkg::ALPHA_FULL);
      default: write_alpha(8'($urandom_range(0, 255)));
    endcase
    l = $urandom_range(0, 4000);
    t = $urandom_range(0, 4000);
    case ($urandom_range(0, 6))
      0: write_clip(0, 0, 4096, 4096);
      1, 2: write_clip(l, t, l + $urandom_range(1, 400), t + $urandom_range(1, 400));
      3: write_clip(l, t, l + $urandom_range(1, 4), t + $urandom_range(1, 4));
      4: write_clip($urandom_range(0, 100), $urandom_range(0, 100),
                    $urandom_range(4097, 8191), $urandom_range(4097, 8191));
      5: write_clip(l, t, l - $urandom_range(0, 50), t + 10);
      default: write_clip(0, 0, $urandom_range(1, 4096), $urandom_range(1, 4096));
    endcase
  endtask

  // coordinate near a window span, or anywhere
  function automatic logic [CW-1:0] pick_coord(input int lo, input int hi);
    int a;
    int b;
    a = (lo > 2) ? lo - 2 : 0;
    b = (hi + 1 > COORD_MAX) ? COORD_MAX : hi + 1;
    if (a > COORD_MAX || a > b || $urandom_range(0, 9) < 2) begin
      return CW'($urandom_range(0, COORD_MAX));
    end
    return CW'($urandom_range(a, b));
  endfunction

  task automatic send_random_pixel();
    logic [23:0] d;
    logic [7:0] a;
    case ($urandom_range(0, 9))
      0: d = BLACK;
      1: d = WHITE;
      default: d = 24'($urandom_range(0, 24'hFFFFFF));
    endcase
    case ($urandom_range(0, 9))
      0, 1: a = 8'd0;
      2, 3: a = 8'd255;
      4: a = $urandom_range(0, 1) ? 8'd127 : 8'd128;
      5: a = $urandom_range(0, 1) ? 8'd1 : 8'd254;
      default: a = 8'($urandom_range(0, 255));
    endcase
    if (idle_on && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 7));
    send_pixel(pick_coord(int'(clip_l), int'(clip_r)), pick_coord(int'(clip_tp), int'(clip_b)),
               d, a);
  endtask

  // phases of random pixels under random settings; phase 3 and the last run without idling
  task automatic test_random_phases();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      pick_setting();
      idle_on = (p != 3) && (p != PHASE_COUNT - 1);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (p == 4 && i == PHASE_PIXELS / 2) wait_results();
        send_random_pixel();
      end
      drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_blend_weights();
    test_clip_edges();
    test_unknown_index();
    test_random_phases();
    drain();
    $display("covered %0d pixel transfers (%0d written, %0d dropped) over %0d settings",
             pixels_sent, pixels_written, pixels_sent - pixels_written, settings_used);
    $display("%0d results checked, %0d errors", results_checked, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // overall timeout
  initial begin
    #400000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
